[src/lpss_pkg.sv]
`default_nettype none

package lpss_pkg;

    // Command codes of the input channel
    localparam logic [2:0] CMD_LOAD       = 3'd0;
    localparam logic [2:0] CMD_BTN0_LONG  = 3'd2;
    localparam logic [2:0] CMD_BTN1_SHORT = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT    = 3'd5;

    // Duty per mA in units of 1/65536 of full scale, and its saturation point
    localparam logic [20:0] DUTY_PER_MA = 21'd19;
    localparam logic [15:0] DUTY_MAX    = 16'hFFFF;

    // Table address is wide enough for 8 profiles of 16 steps
    localparam int ADDR_W = 7;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One job handed from the front to the back
    typedef struct packed {
        logic              do_write;
        logic              do_read;
        logic              fire;
        logic              status;
        logic              running;
        logic [2:0]        profile;
        logic [3:0]        step;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       duty;
        logic [15:0]       delay;
    } t_job;

endpackage

`default_nettype wire

[src/load_profile_step_sequencer_core.sv]
`default_nettype none
// Path from input transfer to result valid: queue entry, registered table read, output register.
// Throughput: one item per cycle while the output is not stalled; the 4-entry job queue
// absorbs short output stalls before the input stall rises.
// Reset: synchronous, active low; clears run flag, selection, step counts and positions,
// profile_count and all handshake state. The step tables are not cleared.
// Config writes take effect on the next cycle.

module load_profile_step_sequencer_core #(
    parameter int MAX_STEPS    = 16,
    parameter int MAX_PROFILES = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [2:0]  i_profile_index,
    input  wire logic [3:0]  i_step_index,
    input  wire logic [15:0] i_load_current_ma,
    input  wire logic [15:0] i_step_delay_ms,
    input  wire logic        i_last_entry,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_running,
    output logic [2:0]       o_active_profile,
    output logic [3:0]       o_active_step,
    output logic [15:0]      o_pwm_duty,
    output logic             o_pwm_enable,
    output logic             o_timer_start,
    output logic [15:0]      o_timer_delay_ms,
    output logic [7:0]       o_led_pattern,
    output logic             o_status
);

    localparam int DEPTH = MAX_PROFILES * MAX_STEPS;

    lpss_pkg::t_job front_job, head_job;
    logic           accept, q_empty, q_full, q_pop;

    // Input transfer
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    lpss_front #(
        .MAX_STEPS   (MAX_STEPS),
        .MAX_PROFILES(MAX_PROFILES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_command        (i_command),
        .i_profile_index  (i_profile_index),
        .i_step_index     (i_step_index),
        .i_load_current_ma(i_load_current_ma),
        .i_step_delay_ms  (i_step_delay_ms),
        .i_last_entry     (i_last_entry),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_job            (front_job)
    );

    lpss_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_job  (front_job),
        .i_pop  (q_pop),
        .o_head (head_job),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    lpss_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_job),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_running       (o_running),
        .o_active_profile(o_active_profile),
        .o_active_step   (o_active_step),
        .o_pwm_duty      (o_pwm_duty),
        .o_pwm_enable    (o_pwm_enable),
        .o_timer_start   (o_timer_start),
        .o_timer_delay_ms(o_timer_delay_ms),
        .o_led_pattern   (o_led_pattern),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire

[src/lpss_front.sv]
`default_nettype none

module lpss_front #(
    parameter int MAX_STEPS    = 16,
    parameter int MAX_PROFILES = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [2:0]        i_command,
    input  wire logic [2:0]        i_profile_index,
    input  wire logic [3:0]        i_step_index,
    input  wire logic [15:0]       i_load_current_ma,
    input  wire logic [15:0]       i_step_delay_ms,
    input  wire logic              i_last_entry,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_data,
    output lpss_pkg::t_job         o_job
);

    localparam int PIW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;

    // Control state
    logic             r_run, n_run;
    logic [2:0]       r_sel, n_sel;
    logic [2:0]       r_pc;
    logic [3:0]       r_pos [MAX_PROFILES];
    logic [3:0]       n_pos [MAX_PROFILES];
    logic [4:0]       r_tot [MAX_PROFILES];
    logic [4:0]       n_tot [MAX_PROFILES];

    logic [2:0]       cur_p, out_p, wrap;
    logic [PIW-1:0]   cur_i, out_i, pin_i;
    logic [3:0]       nxt_p, out_s;
    logic [4:0]       nxt_s;
    logic             load_bad, status, fire, do_write, do_read;
    logic [20:0]      prod;
    logic [15:0]      duty;

    // Current to duty, saturated
    assign prod = {5'd0, i_load_current_ma} * lpss_pkg::DUTY_PER_MA;
    assign duty = (prod > {5'd0, lpss_pkg::DUTY_MAX}) ? lpss_pkg::DUTY_MAX : prod[15:0];

    // Command decode and next state
    always_comb begin
        n_run    = r_run;
        n_sel    = r_sel;
        n_pos    = r_pos;
        n_tot    = r_tot;
        status   = 1'b0;
        fire     = 1'b0;
        do_write = 1'b0;
        cur_p    = (r_sel < 3'(MAX_PROFILES)) ? r_sel : 3'd0;
        cur_i    = cur_p[PIW-1:0];
        pin_i    = i_profile_index[PIW-1:0];
        wrap     = (r_pc < 3'(MAX_PROFILES)) ? r_pc : 3'(MAX_PROFILES);
        nxt_p    = {1'b0, cur_p} + 4'd1;
        nxt_s    = {1'b0, r_pos[cur_i]} + 5'd1;
        load_bad = r_run || ({1'b0, i_profile_index} >= 4'(MAX_PROFILES))
                   || ({1'b0, i_step_index} >= 5'(MAX_STEPS));
        if (i_command == lpss_pkg::CMD_LOAD) begin
            if (load_bad) begin
                status = 1'b1;
            end else begin
                do_write = 1'b1;
                if (i_last_entry) begin
                    n_tot[pin_i] = {1'b0, i_step_index} + 5'd1;
                    n_pos[pin_i] = 4'd0;
                end
            end
        end else if (!r_run) begin
            if (i_command == lpss_pkg::CMD_BTN0_LONG) begin
                n_run        = 1'b1;
                n_pos[cur_i] = 4'd0;
                fire         = 1'b1;
            end else if (i_command == lpss_pkg::CMD_BTN1_SHORT) begin
                n_sel = (nxt_p >= {1'b0, wrap}) ? 3'd0 : nxt_p[2:0];
            end
        end else begin
            if (i_command == lpss_pkg::CMD_BTN0_LONG) begin
                n_run        = 1'b0;
                n_pos[cur_i] = 4'd0;
            end else if (i_command == lpss_pkg::CMD_TIMEOUT) begin
                n_pos[cur_i] = (nxt_s >= r_tot[cur_i]) ? 4'd0 : nxt_s[3:0];
                fire         = 1'b1;
            end
        end
        out_p   = (n_sel < 3'(MAX_PROFILES)) ? n_sel : 3'd0;
        out_i   = out_p[PIW-1:0];
        out_s   = n_pos[out_i];
        do_read = n_run && (n_tot[out_i] != 5'd0);
    end

    // Job for the back part
    always_comb begin
        o_job.do_write = do_write;
        o_job.do_read  = do_read;
        o_job.fire     = fire;
        o_job.status   = status;
        o_job.running  = n_run;
        o_job.profile  = out_p;
        o_job.step     = out_s;
        o_job.duty     = duty;
        o_job.delay    = i_step_delay_ms;
        if (do_write) begin
            o_job.addr = lpss_pkg::ADDR_W'(i_profile_index) * lpss_pkg::ADDR_W'(MAX_STEPS)
                         + lpss_pkg::ADDR_W'(i_step_index);
        end else if (do_read) begin
            o_job.addr = lpss_pkg::ADDR_W'(out_p) * lpss_pkg::ADDR_W'(MAX_STEPS)
                         + lpss_pkg::ADDR_W'(out_s);
        end else begin
            o_job.addr = '0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_sel <= 3'd0;
            r_pc  <= 3'd0;
            for (int k = 0; k < MAX_PROFILES; k++) begin
                r_pos[k] <= 4'd0;
                r_tot[k] <= 5'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_data;
            end
            if (i_accept) begin
                r_run <= n_run;
                r_sel <= n_sel;
                r_pos <= n_pos;
                r_tot <= n_tot;
            end
        end
    end

    // Selection never leaves the profile range
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel < 3'(MAX_PROFILES))
        else $error("selected profile out of range");

    // Step of the selected profile is zero or stays below its step count
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[cur_i] == 4'd0) || ({1'b0, r_pos[cur_i]} < r_tot[cur_i]))
        else $error("step position beyond step count");

endmodule

`default_nettype wire

[src/lpss_queue.sv]
`default_nettype none

module lpss_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lpss_pkg::t_job i_job,
    input  wire logic           i_pop,
    output lpss_pkg::t_job      o_head,
    output logic                o_empty,
    output logic                o_full
);

    lpss_pkg::t_job                r_mem [lpss_pkg::QUEUE_DEPTH];
    logic [lpss_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [lpss_pkg::QUEUE_AW:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (lpss_pkg::QUEUE_AW+1)'(lpss_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Occupancy and pointer distance agree
    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_cnt[lpss_pkg::QUEUE_AW-1:0])
        else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

[src/lpss_back.sv]
`default_nettype none

module lpss_back #(
    parameter int DEPTH = 96
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lpss_pkg::t_job i_head,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic                o_running,
    output logic [2:0]          o_active_profile,
    output logic [3:0]          o_active_step,
    output logic [15:0]         o_pwm_duty,
    output logic                o_pwm_enable,
    output logic                o_timer_start,
    output logic [15:0]         o_timer_delay_ms,
    output logic [7:0]          o_led_pattern,
    output logic                o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Step table: duty in the upper half, delay in the lower half
    logic [31:0]    r_table [DEPTH];
    logic [31:0]    r_rdata;

    logic           r_b_valid;
    lpss_pkg::t_job r_b_job;
    logic           r_o_valid;
    logic           out_ready, b_advance, b_free;
    logic [AW-1:0]  addr;
    logic [15:0]    rd_duty, rd_delay, duty, tdelay;

    assign addr      = i_head.addr[AW-1:0];
    assign out_ready = !r_o_valid || !i_stall;
    assign b_advance = r_b_valid && out_ready;
    assign b_free    = !r_b_valid || b_advance;
    assign o_pop     = !i_empty && b_free;
    assign o_valid   = r_o_valid;

    // Table write and registered read at pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_head.do_write) begin
                r_table[addr] <= {i_head.duty, i_head.delay};
            end
            r_rdata <= r_table[addr];
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_job <= i_head;
        end
    end

    // Result formatting
    assign rd_duty  = r_rdata[31:16];
    assign rd_delay = r_rdata[15:0];
    assign duty     = r_b_job.do_read ? rd_duty : 16'd0;
    assign tdelay   = (r_b_job.do_read && r_b_job.fire) ? rd_delay : 16'd0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance) begin
            o_running        <= r_b_job.running;
            o_active_profile <= r_b_job.profile;
            o_active_step    <= r_b_job.step;
            o_pwm_duty       <= duty;
            o_pwm_enable     <= r_b_job.running;
            o_timer_start    <= (tdelay != 16'd0);
            o_timer_delay_ms <= tdelay;
            o_led_pattern    <= {r_b_job.step + 4'd1, r_b_job.profile + 3'd1,
                                 r_b_job.running};
            o_status         <= r_b_job.status;
        end
    end

    // A held read stage stays occupied
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !out_ready) |=> r_b_valid)
        else $error("read stage dropped a job");

    // Nonzero duty or a timer request only while playing
    a_duty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && ((o_pwm_duty != 16'd0) || o_timer_start)) |-> o_running)
        else $error("duty or timer while stopped");

endmodule

`default_nettype wire
